// ===== rtl/core/diff_drive_arc_odometry_top_defines.svh =====
// ----------------------------------------------------------------------------
// diff drive arc odometry assertion macros
// shared assertion wrappers clocked on clk_i; DIFFO_ASSERT is disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ARC_ODOMETRY_TOP_DEFINES_SVH
`define DIFF_DRIVE_ARC_ODOMETRY_TOP_DEFINES_SVH

// checked only outside reset
`define DIFFO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define DIFFO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/diffo_pkg.sv =====
// ----------------------------------------------------------------------------
// diffo_pkg
// widths, reset values, codes and item types of the arc odometry block
// ----------------------------------------------------------------------------
package diffo_pkg;

  // field widths
  localparam int TICK_W     = 16;
  localparam int SCALE_W    = 16;
  localparam int TRACK_W    = 10;
  localparam int MIN_W      = 20;
  localparam int RADIUS_W   = 11;
  localparam int ARC_OUT_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // datapath widths
  localparam int DIST_W     = TICK_W + SCALE_W;       // signed wheel distance, q.16 mm
  localparam int D_W        = DIST_W - 1;             // outer minus inner, turning case
  localparam int X_W        = DIST_W + TRACK_W + 1;   // signed radius numerator
  localparam int RN_W       = X_W + 1;                // rounded radius dividend
  localparam int THR_W      = D_W + 11;               // clamp threshold
  localparam int ARC_SHIFT  = 17;                     // 2 * 2^16 of the arc divisor
  localparam int ARC_SUM_W  = X_W + 5;
  localparam int AN_W       = ARC_SUM_W - ARC_SHIFT;
  localparam int RAD_Q_W    = 10;                     // quotient bits below clamp
  localparam int ARC_Q_W    = 15;                     // quotient bits below saturation
  localparam int ARC_W      = ((AN_W > TRACK_W + ARC_Q_W + 1) ? AN_W :
                               TRACK_W + ARC_Q_W + 1) + 1;
  localparam int DIV_STAGES = ARC_Q_W;

  // register reset values
  localparam logic [SCALE_W-1:0] TICK_SCALE_RST  = 16'd4293;
  localparam logic [TRACK_W-1:0] TRACK_WIDTH_RST = 10'd100;
  localparam logic [MIN_W-1:0]   MIN_TRAVEL_RST  = 20'd13107;

  // constants
  localparam logic [RAD_Q_W-1:0]   RAD_MAX       = 10'd999;
  localparam logic [10:0]          RAD_CLAMP_MUL = 11'd1998;  // 2 * 999
  localparam logic [RADIUS_W-1:0]  RIGHT_OFFSET  = 11'd1000;
  localparam logic [ARC_OUT_W-1:0] ARC_POS_SAT   = 16'h7FFF;
  localparam logic [ARC_OUT_W-1:0] ARC_NEG_SAT   = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_SCALE  = 2'd0,
    CFG_TRACK_WIDTH = 2'd1,
    CFG_MIN_TRAVEL  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [TICK_W-1:0] left_ticks;
    logic signed [TICK_W-1:0] right_ticks;
  } in_t;

  typedef struct packed {
    logic [RADIUS_W-1:0]         radius_code;
    logic signed [ARC_OUT_W-1:0] arc_length;
  } out_t;

  // state of both restoring dividers as it moves down the pipe
  typedef struct packed {
    logic [RN_W-1:0]    rad_rem;
    logic [D_W:0]       rad_den;
    logic [RAD_Q_W-1:0] rad_q;
    logic               rad_done;
    logic [ARC_W-1:0]   arc_rem;
    logic [TRACK_W-1:0] arc_den;
    logic [ARC_Q_W-1:0] arc_q;
    logic               arc_sat;
    logic               arc_neg;
    logic               arc_zero;
    logic               turn_right;
  } div_t;

endpackage

// ===== rtl/core/diffo_div_pipe.sv =====
// ----------------------------------------------------------------------------
// diffo_div_pipe
// radius and arc restoring dividers, one arc quotient bit per stage, radius bits in the leading stages only
// ----------------------------------------------------------------------------
module diffo_div_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  diffo_pkg::div_t    in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output diffo_pkg::div_t    out_data_o
);

  localparam int N = diffo_pkg::DIV_STAGES;

  logic            vld_q [N];
  diffo_pkg::div_t st_q  [N];
  logic            free  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int RB = (k < diffo_pkg::RAD_Q_W) ? diffo_pkg::RAD_Q_W - 1 - k : 0;
    localparam int AB = diffo_pkg::ARC_Q_W - 1 - k;

    diffo_pkg::div_t              src;
    diffo_pkg::div_t              nxt_d;
    logic                         src_valid;
    logic [diffo_pkg::RN_W-1:0]   rad_trial;
    logic                         rad_hit;
    logic [diffo_pkg::ARC_W-1:0]  arc_trial;
    logic                         arc_hit;

    if (k == 0) begin : g_head
      assign src       = in_data_i;
      assign src_valid = in_valid_i;
    end else begin : g_link
      assign src       = st_q[k-1];
      assign src_valid = vld_q[k-1];
    end

    // a stage moves when it is empty or the stage after it moves
    if (k == N - 1) begin : g_tail
      assign free[k] = ~vld_q[k] | ~out_stall_i;
    end else begin : g_mid
      assign free[k] = ~vld_q[k] | free[k+1];
    end

    if (k < diffo_pkg::RAD_Q_W) begin : g_rad
      assign rad_trial = {{(diffo_pkg::RN_W - diffo_pkg::D_W - 1){1'b0}}, src.rad_den} << RB;
      assign rad_hit   = ~src.rad_done & (src.rad_rem >= rad_trial);
    end else begin : g_rad_idle
      assign rad_trial = '0;
      assign rad_hit   = 1'b0;
    end

    assign arc_trial = {{(diffo_pkg::ARC_W - diffo_pkg::TRACK_W){1'b0}}, src.arc_den} << AB;
    assign arc_hit   = src.arc_rem >= arc_trial;

    always_comb begin
      nxt_d = src;
      if (rad_hit) begin
        nxt_d.rad_rem   = src.rad_rem - rad_trial;
        nxt_d.rad_q[RB] = 1'b1;
      end
      if (arc_hit) begin
        nxt_d.arc_rem   = src.arc_rem - arc_trial;
        nxt_d.arc_q[AB] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (free[k]) begin
        vld_q[k] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (free[k]) begin
        st_q[k] <= nxt_d;
      end
    end
  end

  assign in_stall_o  = ~free[0];
  assign out_valid_o = vld_q[N-1];
  assign out_data_o  = st_q[N-1];

endmodule

// ===== rtl/core/diff_drive_arc_odometry_top.sv =====
// ----------------------------------------------------------------------------
// diff_drive_arc_odometry_top
// centre turn radius and arc length from left and right tick totals
// ----------------------------------------------------------------------------
// usage
//  - input channel in_valid_i / in_stall_o / in_data_i carries one window's
//    left and right tick totals; an item is taken when valid is high and
//    stall is low
//  - output channel out_valid_o / out_stall_i / out_data_o returns one item
//    per input item with radius_code and arc_length, in input order
//  - cfg_we_i / cfg_idx_i / cfg_data_i write tick_scale, track_width and
//    min_travel; write only while no item is in flight, unknown indexes
//    are dropped
//  - 21 register stages: five front stages (scale multiply, wheel ordering,
//    two multiplies, sum and clamp threshold, divider setup), fifteen divider
//    stages with one arc quotient bit each, and the output register
//  - throughput is one item per cycle while the output is not stalled
//  - reset drops all items in flight and loads the register defaults
//  - on an output stall the pipe keeps filling its empty stages and only
//    stalls the input once every stage holds an item
// ----------------------------------------------------------------------------
module diff_drive_arc_odometry_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  diffo_pkg::in_t                     in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output diffo_pkg::out_t                    out_data_o,
  input  logic                               cfg_we_i,
  input  logic [diffo_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [diffo_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // configuration registers
  logic [diffo_pkg::SCALE_W-1:0] tick_scale_q;
  logic [diffo_pkg::TRACK_W-1:0] track_width_q;
  logic [diffo_pkg::MIN_W-1:0]   min_travel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_scale_q  <= diffo_pkg::TICK_SCALE_RST;
      track_width_q <= diffo_pkg::TRACK_WIDTH_RST;
      min_travel_q  <= diffo_pkg::MIN_TRAVEL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        diffo_pkg::CFG_TICK_SCALE:  tick_scale_q  <= cfg_data_i[diffo_pkg::SCALE_W-1:0];
        diffo_pkg::CFG_TRACK_WIDTH: track_width_q <= cfg_data_i[diffo_pkg::TRACK_W-1:0];
        diffo_pkg::CFG_MIN_TRAVEL:  min_travel_q  <= cfg_data_i[diffo_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // half track and centre offset (track minus half)
  logic [diffo_pkg::TRACK_W-2:0] half;
  logic [diffo_pkg::TRACK_W-1:0] ctr_off;
  assign half    = track_width_q[diffo_pkg::TRACK_W-1:1];
  assign ctr_off = track_width_q - {1'b0, half};

  // stage valids and the move chain, output register last
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic free1, free2, free3, free4, free5, free_out;
  logic div_stall;
  logic div_valid;
  diffo_pkg::div_t div_out;
  logic out_valid_q;

  assign free_out = ~out_valid_q | ~out_stall_i;
  assign free5    = ~v5_q | ~div_stall;
  assign free4    = ~v4_q | free5;
  assign free3    = ~v3_q | free4;
  assign free2    = ~v2_q | free3;
  assign free1    = ~v1_q | free2;
  assign in_stall_o = ~free1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (free1)    v1_q <= in_valid_i;
      if (free2)    v2_q <= v1_q;
      if (free3)    v3_q <= v2_q;
      if (free4)    v4_q <= v3_q;
      if (free5)    v5_q <= v4_q;
      if (free_out) out_valid_q <= div_valid;
    end
  end

  // stage 1: ticks to q.16 mm distances
  logic signed [diffo_pkg::DIST_W-1:0] left_d, right_d;
  logic signed [diffo_pkg::DIST_W-1:0] s1_left_q, s1_right_q;
  assign left_d  = $signed(in_data_i.left_ticks)  * $signed({1'b0, tick_scale_q});
  assign right_d = $signed(in_data_i.right_ticks) * $signed({1'b0, tick_scale_q});

  always_ff @(posedge clk_i) begin
    if (free1) begin
      s1_left_q  <= left_d;
      s1_right_q <= right_d;
    end
  end

  // stage 2: pick outer and inner wheel, classify the case
  logic                                turn_d, small_d, eq_d;
  logic signed [diffo_pkg::DIST_W-1:0] outer_d, inner_d;
  logic signed [diffo_pkg::DIST_W-1:0] s2_outer_q, s2_inner_q;
  logic                                s2_turn_q, s2_small_q, s2_eq_q;

  assign turn_d  = s1_right_q < s1_left_q;
  assign outer_d = turn_d ? s1_left_q : s1_right_q;
  assign inner_d = turn_d ? s1_right_q : s1_left_q;
  // signed compare, a negative inner distance counts as small
  assign small_d = inner_d < $signed({{(diffo_pkg::DIST_W - diffo_pkg::MIN_W){1'b0}},
                                      min_travel_q});
  assign eq_d    = s1_left_q == s1_right_q;

  always_ff @(posedge clk_i) begin
    if (free2) begin
      s2_outer_q <= outer_d;
      s2_inner_q <= inner_d;
      s2_turn_q  <= turn_d;
      s2_small_q <= small_d;
      s2_eq_q    <= eq_d;
    end
  end

  // stage 3: x = (trk - half) * outer + half * inner, inner term dropped when small
  // straight case folds in since inner equals outer there
  logic signed [diffo_pkg::DIST_W-1:0] diff_full;
  logic signed [diffo_pkg::X_W-1:0]    po_d, pi_d;
  logic signed [diffo_pkg::X_W-1:0]    s3_po_q, s3_pi_q;
  logic [diffo_pkg::D_W-1:0]           s3_diff_q;
  logic                                s3_fixed_q, s3_turn_q;
  logic [diffo_pkg::RAD_Q_W-1:0]       s3_radv_q;

  assign po_d      = s2_outer_q * $signed({1'b0, ctr_off});
  assign pi_d      = s2_small_q ? '0 : s2_inner_q * $signed({1'b0, half});
  assign diff_full = s2_outer_q - s2_inner_q;

  always_ff @(posedge clk_i) begin
    if (free3) begin
      s3_po_q    <= po_d;
      s3_pi_q    <= pi_d;
      s3_diff_q  <= diff_full[diffo_pkg::D_W-1:0];
      s3_fixed_q <= s2_small_q | s2_eq_q;
      s3_radv_q  <= s2_small_q ? ctr_off : diffo_pkg::RAD_MAX;
      s3_turn_q  <= s2_turn_q;
    end
  end

  // stage 4: sum, magnitude, radius clamp threshold 1998 * d
  logic signed [diffo_pkg::X_W-1:0] x_d;
  logic [diffo_pkg::X_W-1:0]        mag_d;
  logic [diffo_pkg::THR_W-1:0]      thr_d;
  logic [diffo_pkg::X_W-1:0]        s4_mag_q;
  logic                             s4_neg_q, s4_fixed_q, s4_turn_q;
  logic [diffo_pkg::D_W-1:0]        s4_diff_q;
  logic [diffo_pkg::THR_W-1:0]      s4_thr_q;
  logic [diffo_pkg::RAD_Q_W-1:0]    s4_radv_q;

  assign x_d   = s3_po_q + s3_pi_q;
  assign mag_d = x_d[diffo_pkg::X_W-1] ? $unsigned(-x_d) : $unsigned(x_d);
  assign thr_d = s3_diff_q * diffo_pkg::RAD_CLAMP_MUL;

  always_ff @(posedge clk_i) begin
    if (free4) begin
      s4_mag_q   <= mag_d;
      s4_neg_q   <= x_d[diffo_pkg::X_W-1];
      s4_diff_q  <= s3_diff_q;
      s4_thr_q   <= thr_d;
      s4_fixed_q <= s3_fixed_q;
      s4_radv_q  <= s3_radv_q;
      s4_turn_q  <= s3_turn_q;
    end
  end

  // stage 5: divider setup
  // radius: round(x / d) = floor((2x + d) / 2d), clamped when 2x + d >= 1998 d
  // arc: round(10 |x| / (trk << 16)) = floor(((20 |x| + (trk << 16)) >> 17) / trk)
  logic [diffo_pkg::RN_W-1:0]      rn_d;
  logic                            clamp_d;
  logic [diffo_pkg::ARC_SUM_W-1:0] arc_sum;
  logic [diffo_pkg::ARC_W-1:0]     arc_num;
  logic [diffo_pkg::ARC_W-1:0]     arc_lim;
  diffo_pkg::div_t                 div_d;
  diffo_pkg::div_t                 s5_q;

  assign rn_d    = {s4_mag_q, 1'b0}
                 + {{(diffo_pkg::RN_W - diffo_pkg::D_W){1'b0}}, s4_diff_q};
  assign clamp_d = rn_d >= {{(diffo_pkg::RN_W - diffo_pkg::THR_W){1'b0}}, s4_thr_q};
  assign arc_sum = {1'b0, s4_mag_q, 4'b0000}
                 + {3'b000, s4_mag_q, 2'b00}
                 + {{(diffo_pkg::ARC_SUM_W - diffo_pkg::TRACK_W - 16){1'b0}},
                    track_width_q, 16'h0000};
  assign arc_num = {{(diffo_pkg::ARC_W - diffo_pkg::AN_W){1'b0}},
                    arc_sum[diffo_pkg::ARC_SUM_W-1:diffo_pkg::ARC_SHIFT]};
  assign arc_lim = {{(diffo_pkg::ARC_W - diffo_pkg::TRACK_W){1'b0}}, track_width_q}
                   << diffo_pkg::ARC_Q_W;

  always_comb begin
    div_d.rad_rem    = rn_d;
    div_d.rad_den    = {s4_diff_q, 1'b0};
    div_d.rad_done   = s4_fixed_q | clamp_d;
    div_d.rad_q      = s4_fixed_q ? s4_radv_q :
                       clamp_d    ? diffo_pkg::RAD_MAX : '0;
    div_d.arc_rem    = arc_num;
    div_d.arc_den    = track_width_q;
    div_d.arc_q      = '0;
    div_d.arc_sat    = arc_num >= arc_lim;
    div_d.arc_neg    = s4_neg_q;
    div_d.arc_zero   = track_width_q == '0;
    div_d.turn_right = s4_turn_q;
  end

  always_ff @(posedge clk_i) begin
    if (free5) begin
      s5_q <= div_d;
    end
  end

  // stages 6 to 20: dividers
  diffo_div_pipe u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v5_q),
    .in_stall_o  (div_stall),
    .in_data_i   (s5_q),
    .out_valid_o (div_valid),
    .out_stall_i (~free_out),
    .out_data_o  (div_out)
  );

  // output register: right turn offset, zero track, arc saturation and sign
  logic [diffo_pkg::ARC_OUT_W-1:0] arc_mag;
  diffo_pkg::out_t                 out_d;
  diffo_pkg::out_t                 out_q;

  assign arc_mag = {1'b0, div_out.arc_q};

  always_comb begin
    out_d.radius_code = {1'b0, div_out.rad_q}
                      + (div_out.turn_right ? diffo_pkg::RIGHT_OFFSET : '0);
    if (div_out.arc_zero) begin
      out_d.arc_length = '0;
    end else if (div_out.arc_sat) begin
      out_d.arc_length = div_out.arc_neg ? diffo_pkg::ARC_NEG_SAT : diffo_pkg::ARC_POS_SAT;
    end else if (div_out.arc_neg) begin
      out_d.arc_length = -arc_mag;
    end else begin
      out_d.arc_length = arc_mag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/diffo_checker.sv =====
// ----------------------------------------------------------------------------
// diffo_checker
// port level checks of the arc odometry block
// ----------------------------------------------------------------------------
`include "diff_drive_arc_odometry_top_defines.svh"

module diffo_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input diffo_pkg::out_t out_data_o
);

  // nothing leaves the block while it is held in reset
  `DIFFO_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_o, "output valid in reset")

  // input backpressure only when every stage is full and the output is blocked
  `DIFFO_ASSERT(a_stall_only_full, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled with room in pipe")

  // radius code is a clamped radius plus an optional right turn offset
  `DIFFO_ASSERT(a_radius_range, out_valid_o |-> (out_data_o.radius_code < 11'd2000), "radius code out of range")

  // a blocked result stays put
  `DIFFO_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)), "stalled output changed")

endmodule

bind diff_drive_arc_odometry_top diffo_checker u_diffo_checker (.*);

// ===== verif/tb_diff_drive_arc_odometry_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_diff_drive_arc_odometry_top
// drives tick-total windows into the arc odometry pipe under several register
// settings and random idling on both channels. A scoreboard computes the
// expected radius code and arc length of every accepted window and compares
// them, field by field and in order, with the items the block returns.
// ----------------------------------------------------------------------------
module tb_diff_drive_arc_odometry_top;
  import diffo_pkg::*;

  // write to this index must leave every register untouched
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam int PIPE_DEPTH = 21;
  localparam int HOLD_CYCLES = 80;
  localparam int REPORT_LIMIT = 10;

  // expected results of accepted windows, plus a private copy of the registers
  class arc_odometry_scoreboard;
    logic [SCALE_W-1:0] tick_scale;
    logic [TRACK_W-1:0] track_width;
    logic [MIN_W-1:0]   min_travel;
    out_t expected_arcs[$];
    int failures;

    function new();
      tick_scale  = TICK_SCALE_RST;
      track_width = TRACK_WIDTH_RST;
      min_travel  = MIN_TRAVEL_RST;
      failures    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_TICK_SCALE:  tick_scale  = val[SCALE_W-1:0];
        CFG_TRACK_WIDTH: track_width = val[TRACK_W-1:0];
        CFG_MIN_TRAVEL:  min_travel  = val[MIN_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_arcs.size();
    endfunction

    // x / d rounded half away from zero, negative clamps to zero, top at 999
    function longint round_radius(longint x, longint d);
      longint q;
      longint rem;
      if (x < 0) return 0;
      q = x / d;
      rem = x % d;
      if (2 * rem >= d) q++;
      return (q > 999) ? 999 : q;
    endfunction

    // 10 * x / d rounded half away from zero, saturated to 16 bits signed
    function logic [ARC_OUT_W-1:0] round_arc(longint x, longint d);
      longint m;
      longint q;
      longint rem;
      longint v;
      longint rem10;
      m = (x < 0) ? -x : x;
      q = m / d;
      rem = m % d;
      v = 10 * q + (10 * rem) / d;
      rem10 = (10 * rem) % d;
      if (2 * rem10 >= d) v++;
      if (x < 0) begin
        if (v > 32768) v = 32768;
        return ARC_OUT_W'(-v);
      end
      if (v > 32767) v = 32767;
      return ARC_OUT_W'(v);
    endfunction

    function out_t predict_arc(in_t w);
      longint lft;
      longint rgt;
      longint outer;
      longint inner;
      longint trk;
      longint half;
      longint x;
      longint rad;
      bit right_turn;
      out_t r;
      lft = longint'($signed(w.left_ticks)) * longint'(tick_scale);
      rgt = longint'($signed(w.right_ticks)) * longint'(tick_scale);
      right_turn = (rgt < lft);
      outer = right_turn ? lft : rgt;
      inner = right_turn ? rgt : lft;
      trk = longint'(track_width);
      half = longint'(track_width >> 1);
      if (inner < longint'(min_travel)) begin
        // inner wheel hardly moved: outer radius is the track itself
        rad = trk - half;
        if (rad > 999) rad = 999;
        x = outer * (trk - half);
      end else if (outer != inner) begin
        x = trk * outer - half * (outer - inner);
        rad = round_radius(x, outer - inner);
      end else begin
        // straight run
        rad = 999;
        x = trk * outer;
      end
      r.radius_code = RADIUS_W'(rad + (right_turn ? longint'(RIGHT_OFFSET) : 0));
      r.arc_length = (track_width == 0) ? '0 : round_arc(x, trk * 65536);
      return r;
    endfunction

    function void note_window(in_t w);
      expected_arcs.push_back(predict_arc(w));
    endfunction

    function void check_arc(out_t got);
      out_t exp_arc;
      if (expected_arcs.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected item: radius_code %0d arc_length %0d",
                   got.radius_code, $signed(got.arc_length));
        return;
      end
      exp_arc = expected_arcs.pop_front();
      if (got.radius_code !== exp_arc.radius_code) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("radius_code mismatch: expected %0d actual %0d",
                   exp_arc.radius_code, got.radius_code);
      end
      if (got.arc_length !== exp_arc.arc_length) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("arc_length mismatch: expected %0d actual %0d",
                   $signed(exp_arc.arc_length), $signed(got.arc_length));
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // idling odds in percent per cycle, and the request for a long output hold
  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_req;
  int hold_left;

  arc_odometry_scoreboard board;

  diff_drive_arc_odometry_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

  // output side: random stalls, or a long hold when asked for one
  initial begin
    out_stall_i = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  // every item leaving the block goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_arc(out_data_o);
  end

  // one register write, only ever issued while the pipe is empty
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = CFG_DATA_W'(val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    board.set_reg(idx, CFG_DATA_W'(val));
  endtask

  // offers one window; valid stays high into the next item unless the sender idles
  task automatic send_window(input in_t w);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = w;
    do @(posedge clk_i); while (in_stall_o);
    board.note_window(w);
    @(negedge clk_i);
  endtask

  function automatic in_t window_of(int l, int r);
    in_t w;
    w.left_ticks = TICK_W'(l);
    w.right_ticks = TICK_W'(r);
    return w;
  endfunction

  function automatic int extreme_ticks();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return -1;
      2: return 0;
      3: return 1;
      default: return 32767;
    endcase
  endfunction

  // mostly turning and straight windows with random content, some raw noise
  function automatic in_t random_window();
    int l;
    int r;
    l = int'($urandom_range(0, 65535)) - 32768;
    case ($urandom_range(0, 5))
      0: r = int'($urandom_range(0, 65535)) - 32768;
      1: r = l + int'($urandom_range(0, 16)) - 8;        // near straight
      2: begin
        l = extreme_ticks();
        r = extreme_ticks();
      end
      3: begin
        l = int'($urandom_range(0, 120)) - 60;
        r = int'($urandom_range(0, 120)) - 60;
      end
      4: r = l;                                          // exactly straight
      default: begin
        l = int'($urandom_range(0, 4000)) - 2000;
        r = int'($urandom_range(0, 4000)) - 2000;
      end
    endcase
    return window_of(l, r);
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_window(random_window());
  endtask

  // let every expected item come back, then let the pipe idle
  task automatic drain_pipe();
    in_valid_i = 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (PIPE_DEPTH + 4) @(negedge clk_i);
  endtask

  task automatic random_setup();
    write_reg(CFG_TICK_SCALE, $urandom_range(0, 65535));
    write_reg(CFG_TRACK_WIDTH, 2 * $urandom_range(1, 511));
    if ($urandom_range(0, 1) == 0) write_reg(CFG_MIN_TRAVEL, $urandom_range(0, 200000));
    else write_reg(CFG_MIN_TRAVEL, $urandom_range(0, (1 << MIN_W) - 1));
  endtask

  initial begin
    board = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    hold_req = 1'b0;
    tx_idle_pct = 20;
    rx_idle_pct = 61;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset values: straight runs, both turn directions, a barely moving
    // inner wheel, a negative inner wheel, field extremes
    send_window(window_of(0, 0));
    send_window(window_of(32767, 32767));
    send_window(window_of(-32768, -32768));
    send_window(window_of(32767, -32768));
    send_window(window_of(-32768, 32767));
    send_window(window_of(100, 100));
    send_window(window_of(3, 3));
    send_window(window_of(4, 4));
    send_window(window_of(1000, 2000));
    send_window(window_of(2000, 1000));
    send_window(window_of(3, 1000));
    send_window(window_of(1000, 3));
    send_window(window_of(-5, 300));
    send_window(window_of(300, -5));
    send_window(window_of(-1, -1));
    send_window(window_of(1, -1));
    send_window(window_of(500, 501));
    send_window(window_of(501, 500));
    send_window(window_of(-32768, -32767));
    send_window(window_of(32766, 32767));
    send_random(80);
    drain_pipe();

    // widest scale, widest even track, no threshold: arc saturates both ways
    write_reg(CFG_TICK_SCALE, 65535);
    write_reg(CFG_TRACK_WIDTH, 1022);
    write_reg(CFG_MIN_TRAVEL, 0);
    send_window(window_of(32767, 32767));
    send_window(window_of(-32768, -32768));
    send_window(window_of(32767, -32768));
    send_random(60);
    drain_pipe();

    // zero scale, narrowest nonzero even track, top threshold
    write_reg(CFG_TICK_SCALE, 0);
    write_reg(CFG_TRACK_WIDTH, 2);
    write_reg(CFG_MIN_TRAVEL, (1 << MIN_W) - 1);
    send_random(40);
    drain_pipe();

    // swap the idling sides
    tx_idle_pct = 61;
    rx_idle_pct = 20;

    // odd track: half is the truncated shift
    write_reg(CFG_TICK_SCALE, 1);
    write_reg(CFG_TRACK_WIDTH, 101);
    write_reg(CFG_MIN_TRAVEL, 1);
    send_random(60);
    drain_pipe();

    // zero track gives a zero arc; the spare index must change nothing
    write_reg(CFG_TICK_SCALE, $urandom_range(0, 65535));
    write_reg(CFG_MIN_TRAVEL, $urandom_range(0, 100000));
    write_reg(CFG_TRACK_WIDTH, 0);
    write_reg(CFG_IDX_SPARE, $urandom_range(0, (1 << CFG_DATA_W) - 1));
    send_random(40);
    drain_pipe();

    random_setup();
    send_random(60);
    drain_pipe();

    // no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;

    // long output hold while windows keep coming, so the pipe backs up
    random_setup();
    hold_req = 1'b1;
    send_random(100);
    drain_pipe();

    random_setup();
    send_random(80);
    drain_pipe();

    // back to the reset values
    write_reg(CFG_TICK_SCALE, TICK_SCALE_RST);
    write_reg(CFG_TRACK_WIDTH, TRACK_WIDTH_RST);
    write_reg(CFG_MIN_TRAVEL, MIN_TRAVEL_RST);
    send_random(60);
    drain_pipe();

    if (board.failures == 0 && board.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
